// ----- sv/lcg48_pkg.sv -----
package lcg48_pkg;

  // Generator state width and the mask that keeps an advance in range.
  localparam int STATE_BITS = 48;
  localparam logic [63:0] STATE_MASK = (64'd1 << STATE_BITS) - 64'd1;

  // Field widths of the request, response and configuration items.
  localparam int KIND_W = 3;
  localparam int SEED_W = 64;
  localparam int BITS_W = 6;
  localparam int BOUND_W = 32;
  localparam int VALUE_W = 64;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MULT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC = 4'd1;
  localparam logic [CFG_DATA_W-1:0] MULT_RESET = 48'd25214903917;
  localparam logic [CFG_DATA_W-1:0] INC_RESET = 48'd11;

  // The advance multiplies in chunks of the old state, one chunk a cycle.
  localparam int CHUNK_W = 16;
  localparam int NCHUNK = (STATE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int PLIER_W = NCHUNK * CHUNK_W;

  // Draw widths used by the different request kinds.
  localparam int DRAW_W = 32;
  localparam int SH_W = 6;
  localparam logic [BITS_W-1:0] DRAW_FULL = 6'd32;
  localparam logic [BITS_W-1:0] DRAW_BOUNDED = 6'd31;
  localparam logic [BITS_W-1:0] DRAW_DBL_HI = 6'd26;
  localparam logic [BITS_W-1:0] DRAW_DBL_LO = 6'd27;
  localparam int DBL_LO_W = 27;

  // Bounded draw: remainder divider and retry budget.
  localparam int DIV_STEPS = 31;
  localparam int REJECT_LIMIT = 1024;
  localparam int TRY_W = $clog2(REJECT_LIMIT);
  localparam int CNT_W = $clog2(DIV_STEPS > NCHUNK ? DIV_STEPS : NCHUNK);

  typedef enum logic [KIND_W-1:0] {
    KIND_SEED    = 3'd0,
    KIND_LOAD    = 3'd1,
    KIND_READ    = 3'd2,
    KIND_ADVANCE = 3'd3,
    KIND_BITS    = 3'd4,
    KIND_BOUNDED = 3'd5,
    KIND_LONG    = 3'd6,
    KIND_DOUBLE  = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADV_START,
    S_ADV_MUL,
    S_COMMIT,
    S_POW,
    S_DIV_INIT,
    S_DIV,
    S_TEST,
    S_FORM,
    S_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic seed_op;
    logic load_op;
    logic read_op;
    logic zero_res;
    logic adv_start;
    logic adv_step;
    logic adv_commit;
    logic second;
    logic pow_mul;
    logic div_start;
    logic div_step;
    logic rem_res;
    logic form_res;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  in_valid;
    kind_e kind;
    logic  bound_ok;
    logic  pow2;
    logic  reject;
    logic  out_free;
  } status_t;

endpackage

// ----- sv/lcg48_if.sv -----
// Request channel: one generator request per item.
interface lcg48_req_if;
  logic                                valid;
  logic                                ready;
  logic        [lcg48_pkg::KIND_W-1:0]  kind;
  logic signed [lcg48_pkg::SEED_W-1:0]  seed_value;
  logic        [lcg48_pkg::BITS_W-1:0]  bit_count;
  logic signed [lcg48_pkg::BOUND_W-1:0] bound;

  modport source (output valid, kind, seed_value, bit_count, bound, input ready);
  modport sink (input valid, kind, seed_value, bit_count, bound, output ready);
endinterface

// Response channel: one result value per item.
interface lcg48_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcg48_pkg::VALUE_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

// Configuration write channel.
interface lcg48_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lcg48_pkg::CFG_IDX_W-1:0]      index;
  logic [lcg48_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/lcg48_ctrl.sv -----
module lcg48_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcg48_pkg::status_t status_i,
  output lcg48_pkg::cmd_t    cmd_o
);

  lcg48_pkg::ctrl_state_e state_q, state_d;
  logic [lcg48_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [lcg48_pkg::TRY_W-1:0] tries_q, tries_d;
  logic second_q, second_d;

  // State register, step counter, retry counter and second-draw flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcg48_pkg::S_IDLE;
      cnt_q    <= '0;
      tries_q  <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      tries_q  <= tries_d;
      second_q <= second_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    tries_d      = tries_q;
    second_d     = second_q;
    cmd_o        = '0;
    cmd_o.second = second_q;
    case (state_q)
      lcg48_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          second_d = 1'b0;
          tries_d  = '0;
          state_d  = lcg48_pkg::S_DISPATCH;
        end
      end
      lcg48_pkg::S_DISPATCH: begin
        case (status_i.kind)
          lcg48_pkg::KIND_SEED: begin
            cmd_o.seed_op = 1'b1;
            state_d = lcg48_pkg::S_OUT;
          end
          lcg48_pkg::KIND_LOAD: begin
            cmd_o.load_op = 1'b1;
            state_d = lcg48_pkg::S_OUT;
          end
          lcg48_pkg::KIND_READ: begin
            cmd_o.read_op = 1'b1;
            state_d = lcg48_pkg::S_OUT;
          end
          lcg48_pkg::KIND_BOUNDED: begin
            // A bound of zero or below answers zero without advancing.
            if (status_i.bound_ok) begin
              state_d = lcg48_pkg::S_ADV_START;
            end else begin
              cmd_o.zero_res = 1'b1;
              state_d = lcg48_pkg::S_OUT;
            end
          end
          default: begin
            state_d = lcg48_pkg::S_ADV_START;
          end
        endcase
      end
      lcg48_pkg::S_ADV_START: begin
        cmd_o.adv_start = 1'b1;
        cnt_d = '0;
        state_d = lcg48_pkg::S_ADV_MUL;
      end
      lcg48_pkg::S_ADV_MUL: begin
        cmd_o.adv_step = 1'b1;
        if (cnt_q == lcg48_pkg::CNT_W'(lcg48_pkg::NCHUNK - 1)) begin
          state_d = lcg48_pkg::S_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lcg48_pkg::S_COMMIT: begin
        cmd_o.adv_commit = 1'b1;
        case (status_i.kind)
          lcg48_pkg::KIND_BOUNDED: begin
            state_d = status_i.pow2 ? lcg48_pkg::S_POW : lcg48_pkg::S_DIV_INIT;
          end
          lcg48_pkg::KIND_LONG, lcg48_pkg::KIND_DOUBLE: begin
            // These kinds take a second draw before the result is formed.
            if (second_q) begin
              state_d = lcg48_pkg::S_FORM;
            end else begin
              second_d = 1'b1;
              state_d = lcg48_pkg::S_ADV_START;
            end
          end
          default: begin
            state_d = lcg48_pkg::S_FORM;
          end
        endcase
      end
      lcg48_pkg::S_POW: begin
        cmd_o.pow_mul = 1'b1;
        state_d = lcg48_pkg::S_OUT;
      end
      lcg48_pkg::S_DIV_INIT: begin
        cmd_o.div_start = 1'b1;
        cnt_d = '0;
        state_d = lcg48_pkg::S_DIV;
      end
      lcg48_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == lcg48_pkg::CNT_W'(lcg48_pkg::DIV_STEPS - 1)) begin
          state_d = lcg48_pkg::S_TEST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lcg48_pkg::S_TEST: begin
        // Accept the remainder, or draw again until the retry budget is spent.
        if (!status_i.reject ||
            tries_q == lcg48_pkg::TRY_W'(lcg48_pkg::REJECT_LIMIT - 1)) begin
          cmd_o.rem_res = 1'b1;
          state_d = lcg48_pkg::S_OUT;
        end else begin
          tries_d = tries_q + 1'b1;
          state_d = lcg48_pkg::S_ADV_START;
        end
      end
      lcg48_pkg::S_FORM: begin
        cmd_o.form_res = 1'b1;
        state_d = lcg48_pkg::S_OUT;
      end
      lcg48_pkg::S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = lcg48_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lcg48_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/lcg48_dpath.sv -----
module lcg48_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  lcg48_req_if.sink          req_i,
  lcg48_rsp_if.source        rsp_o,
  lcg48_cfg_if.sink          cfg_i,
  input  lcg48_pkg::cmd_t    cmd_i,
  output lcg48_pkg::status_t status_o
);

  localparam int SB = lcg48_pkg::STATE_BITS;
  localparam int DW = lcg48_pkg::DRAW_W;
  localparam int VW = lcg48_pkg::VALUE_W;

  // Configuration and generator state.
  logic [lcg48_pkg::CFG_DATA_W-1:0] mult_q, inc_q;
  logic [lcg48_pkg::SEED_W-1:0]     state_q;
  logic                             out_valid_q;

  // Captured request fields.
  lcg48_pkg::kind_e               kind_q;
  logic [lcg48_pkg::SEED_W-1:0]   seed_q;
  logic [lcg48_pkg::BITS_W-1:0]   bits_q;
  logic [lcg48_pkg::BOUND_W-1:0]  bound_q;

  // Working registers.
  logic [SB-1:0]                  acc_q, mcand_q;
  logic [lcg48_pkg::PLIER_W-1:0]  plier_q;
  logic [DW-1:0]                  draw_q, hi_q;
  logic [lcg48_pkg::DIV_STEPS-1:0] rem_q, divd_q;
  logic [VW-1:0]                  res_q, out_q;

  logic                           capture;
  logic [SB+lcg48_pkg::CHUNK_W-1:0] prod;
  logic [lcg48_pkg::BITS_W-1:0]   draw_bits;
  logic [lcg48_pkg::SH_W-1:0]     draw_sh;
  logic [SB-1:0]                  draw_shifted;
  logic [DW-1:0]                  draw_val;
  logic [lcg48_pkg::SEED_W-1:0]   seed_mix;
  logic [2*DW-2:0]                pow_prod;
  logic [DW-1:0]                  trial;
  logic [DW-1:0]                  reject_t;
  logic [VW-1:0]                  draw_sext;

  assign capture     = req_i.valid && cmd_i.in_ready;
  assign req_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.value = out_q;

  // One chunk of the old state times the multiplier.
  assign prod = mcand_q * plier_q[lcg48_pkg::CHUNK_W-1:0];

  // Number of top state bits that the current draw takes.
  always_comb begin
    case (kind_q)
      lcg48_pkg::KIND_BITS: begin
        draw_bits = (bits_q > lcg48_pkg::DRAW_FULL) ? lcg48_pkg::DRAW_FULL : bits_q;
      end
      lcg48_pkg::KIND_BOUNDED: draw_bits = lcg48_pkg::DRAW_BOUNDED;
      lcg48_pkg::KIND_DOUBLE: begin
        draw_bits = cmd_i.second ? lcg48_pkg::DRAW_DBL_LO : lcg48_pkg::DRAW_DBL_HI;
      end
      default: draw_bits = lcg48_pkg::DRAW_FULL;
    endcase
  end

  // The draw comes straight from the freshly advanced state.
  assign draw_sh      = lcg48_pkg::SH_W'(SB) - draw_bits;
  assign draw_shifted = acc_q >> draw_sh;
  assign draw_val     = draw_shifted[DW-1:0];

  assign seed_mix = (seed_q ^ {{(lcg48_pkg::SEED_W - lcg48_pkg::CFG_DATA_W){1'b0}}, mult_q})
                    & lcg48_pkg::STATE_MASK;

  // Power-of-two bound: multiply by the 31-bit draw and keep the top bits.
  assign pow_prod = {{(DW-1){1'b0}}, bound_q} * {{DW{1'b0}}, draw_q[DW-2:0]};

  // Remainder step and rejection test of the bounded draw.
  assign trial     = {rem_q, divd_q[lcg48_pkg::DIV_STEPS-1]};
  assign reject_t  = draw_q - {1'b0, rem_q} + (bound_q - 1'b1);
  assign draw_sext = {{(VW-DW){draw_q[DW-1]}}, draw_q};

  assign status_o.in_valid = req_i.valid;
  assign status_o.kind     = kind_q;
  assign status_o.bound_ok = (bound_q != '0) && !bound_q[lcg48_pkg::BOUND_W-1];
  assign status_o.pow2     = ((bound_q & (~bound_q + 1'b1)) == bound_q);
  assign status_o.reject   = reject_t[DW-1];
  assign status_o.out_free = !out_valid_q || rsp_o.ready;

  // Configuration registers, generator state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q      <= lcg48_pkg::MULT_RESET;
      inc_q       <= lcg48_pkg::INC_RESET;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          lcg48_pkg::CFG_MULT: mult_q <= cfg_i.data;
          lcg48_pkg::CFG_INC:  inc_q  <= cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.seed_op) begin
        state_q <= seed_mix;
      end else if (cmd_i.load_op) begin
        state_q <= seed_q;
      end else if (cmd_i.adv_commit) begin
        state_q <= {{(lcg48_pkg::SEED_W - SB){1'b0}}, acc_q};
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and the advance, draw, divide and result datapath.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      kind_q  <= lcg48_pkg::kind_e'(req_i.kind);
      seed_q  <= req_i.seed_value;
      bits_q  <= req_i.bit_count;
      bound_q <= req_i.bound;
    end
    if (cmd_i.adv_start) begin
      acc_q   <= inc_q[SB-1:0];
      mcand_q <= mult_q[SB-1:0];
      plier_q <= state_q[lcg48_pkg::PLIER_W-1:0];
    end else if (cmd_i.adv_step) begin
      acc_q   <= acc_q + prod[SB-1:0];
      mcand_q <= mcand_q << lcg48_pkg::CHUNK_W;
      plier_q <= plier_q >> lcg48_pkg::CHUNK_W;
    end
    if (cmd_i.adv_commit) begin
      hi_q   <= draw_q;
      draw_q <= draw_val;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      divd_q <= draw_q[lcg48_pkg::DIV_STEPS-1:0];
    end else if (cmd_i.div_step) begin
      if (trial >= bound_q) begin
        rem_q <= lcg48_pkg::DIV_STEPS'(trial - bound_q);
      end else begin
        rem_q <= trial[lcg48_pkg::DIV_STEPS-1:0];
      end
      divd_q <= divd_q << 1;
    end
    if (cmd_i.seed_op) begin
      res_q <= seed_mix;
    end else if (cmd_i.load_op) begin
      res_q <= seed_q;
    end else if (cmd_i.read_op) begin
      res_q <= state_q;
    end else if (cmd_i.zero_res) begin
      res_q <= '0;
    end else if (cmd_i.pow_mul) begin
      res_q <= {{(VW-DW){1'b0}}, pow_prod[2*DW-2:DW-1]};
    end else if (cmd_i.rem_res) begin
      res_q <= {{(VW-lcg48_pkg::DIV_STEPS){1'b0}}, rem_q};
    end else if (cmd_i.form_res) begin
      case (kind_q)
        lcg48_pkg::KIND_BITS: res_q <= draw_sext;
        lcg48_pkg::KIND_LONG: res_q <= {hi_q, {DW{1'b0}}} + draw_sext;
        lcg48_pkg::KIND_DOUBLE: begin
          res_q <= ({{(VW-DW){1'b0}}, hi_q} << lcg48_pkg::DBL_LO_W)
                   + {{(VW-DW){1'b0}}, draw_q};
        end
        default: res_q <= state_q;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// ----- sv/lcg48_random_generator_unit.sv -----
// Seed, load, read and a bound of zero or below need no advance. An advance, a bit draw or a
// power-of-two bound take one advance; a long or double draw takes two advances. Any other
// bounded draw runs the 31-step remainder divider after its advance, and draws again on each
// rejection until it gives up after 1024 attempts.
// One item is in flight at a time; the next item can be taken in the cycle after the result is loaded.
// Reset clears the state to zero and restores the stock multiplier and increment.
module lcg48_random_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcg48_req_if.sink   req_i,
  lcg48_rsp_if.source rsp_o,
  lcg48_cfg_if.sink   cfg_i
);

  lcg48_pkg::cmd_t    cmd;
  lcg48_pkg::status_t status;

  // Sequencer for the request kinds.
  lcg48_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // State, multiplier, divider and output register.
  lcg48_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // An accepted item keeps the request side closed in the following cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while an item is still in work");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten while full");

  // The sequencer issues at most one of its major steps at a time.
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.in_ready, cmd.adv_step, cmd.adv_commit, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import lcg48_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200_000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 212;
  localparam int unsigned MAX_RANDOM_TRIES = 16;
  localparam int unsigned END_SETTLE = 60;
  localparam int unsigned HOLD_PHASE = 0;
  localparam int unsigned PAUSE_PHASE = 6;
  localparam logic [CFG_DATA_W-1:0] DATA_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_INC + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE = '1;

  // One request item as the generator sees it.
  typedef struct packed {
    kind_e               kind;
    logic [SEED_W-1:0]   seed_value;
    logic [BITS_W-1:0]   bit_count;
    logic [BOUND_W-1:0]  bound;
  } request_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef enum logic [1:0] {
    TAKE_ALL,
    TAKE_HALF,
    TAKE_QUARTER,
    TAKE_PATTERN
  } sink_mode_e;

  // Tracks the generator state and the values owed by the block, in order.
  class lcg48_scoreboard;
    logic [63:0]           state;
    logic [CFG_DATA_W-1:0] mult;
    logic [CFG_DATA_W-1:0] incr;
    logic [63:0]           values_due[$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           kind_count[8];

    function new();
      state = '0;
      mult = MULT_RESET;
      incr = INC_RESET;
      mismatches = 0;
      checked = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_MULT: mult = data;
        CFG_INC:  incr = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] sign_extend(logic [31:0] x);
      return {{32{x[31]}}, x};
    endfunction

    // One LCG step; the product wraps at 64 bits before the state mask.
    function logic [63:0] advance();
      state = (64'(mult) * state + 64'(incr)) & STATE_MASK;
      return state;
    endfunction

    // Top bits of the freshly advanced state, at most 32 of them.
    function logic [31:0] draw(logic [BITS_W-1:0] bits);
      logic [63:0]       s;
      logic [BITS_W-1:0] width;
      s = advance();
      width = (bits > DRAW_FULL) ? DRAW_FULL : bits;
      return 32'(s >> (STATE_BITS - width));
    endfunction

    // Bounded integer draw with the wrapped 32-bit rejection test.
    function logic [63:0] bounded(logic [31:0] n, output int unsigned tries);
      logic [31:0] b;
      logic [31:0] v;
      logic [31:0] t;
      v = '0;
      tries = 0;
      if (n == '0 || n[31]) return '0;
      if ((n & (32'd0 - n)) == n) begin
        tries = 1;
        return (64'(n) * 64'(draw(DRAW_BOUNDED))) >> DRAW_BOUNDED;
      end
      while (tries < REJECT_LIMIT) begin
        b = draw(DRAW_BOUNDED);
        v = b % n;
        t = b - v + (n - 32'd1);
        tries++;
        if (!t[31]) break;
      end
      return 64'(v);
    endfunction

    // Number of attempts a bounded draw would take from the current state.
    function int unsigned bounded_tries(logic [31:0] n);
      logic [63:0] saved;
      int unsigned tries;
      saved = state;
      void'(bounded(n, tries));
      state = saved;
      return tries;
    endfunction

    function logic [63:0] compute_value(request_t it);
      int unsigned tries;
      logic [63:0] hi;
      logic [63:0] lo;
      case (it.kind)
        KIND_SEED: begin
          state = (it.seed_value ^ 64'(mult)) & STATE_MASK;
          return state;
        end
        KIND_LOAD: begin
          state = it.seed_value;
          return state;
        end
        KIND_READ: return state;
        KIND_ADVANCE: return advance();
        KIND_BITS: begin
          if (it.bit_count == '0) begin
            void'(advance());
            return '0;
          end
          return sign_extend(draw(it.bit_count));
        end
        KIND_BOUNDED: return bounded(it.bound, tries);
        KIND_LONG: begin
          hi = sign_extend(draw(DRAW_FULL));
          lo = sign_extend(draw(DRAW_FULL));
          return (hi << DRAW_W) + lo;
        end
        default: begin
          hi = 64'(draw(DRAW_DBL_HI));
          lo = 64'(draw(DRAW_DBL_LO));
          return (hi << DBL_LO_W) + lo;
        end
      endcase
    endfunction

    function void note_request(request_t it);
      kind_count[it.kind]++;
      values_due.push_back(compute_value(it));
    endfunction

    function void check_value(logic [63:0] actual);
      logic [63:0] wanted;
      if (values_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected result %h with nothing outstanding", actual);
        end
        return;
      end
      wanted = values_due.pop_front();
      checked++;
      if (actual !== wanted) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Result %0d value mismatch: expected %h, got %h", checked, wanted, actual);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned holds_asked = 0;
  int unsigned holds_started = 0;
  lcg48_scoreboard sb;

  lcg48_req_if req_bus();
  lcg48_rsp_if rsp_bus();
  lcg48_cfg_if cfg_bus();

  lcg48_random_generator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic request_t make_request(kind_e kind, logic [SEED_W-1:0] seed,
                                            logic [BITS_W-1:0] bits,
                                            logic [BOUND_W-1:0] bound);
    request_t it;
    it.kind = kind;
    it.seed_value = seed;
    it.bit_count = bits;
    it.bound = bound;
    return it;
  endfunction

  // Random request: seeding and loading are kept rare so the draws run long.
  function automatic request_t random_request();
    request_t it;
    int unsigned pick;
    pick = $urandom_range(0, 13);
    if (pick == 0) begin
      it.kind = KIND_SEED;
    end else if (pick == 1) begin
      it.kind = KIND_LOAD;
    end else begin
      it.kind = kind_e'($urandom_range(KIND_READ, KIND_DOUBLE));
    end
    case ($urandom_range(0, 7))
      0: it.seed_value = '0;
      1: it.seed_value = '1;
      2: it.seed_value = {1'b1, 63'd0};
      3: it.seed_value = {1'b0, {63{1'b1}}};
      default: it.seed_value = {$urandom(), $urandom()};
    endcase
    if ($urandom_range(0, 7) == 0) begin
      it.bit_count = BITS_W'($urandom_range(0, 63));
    end else begin
      it.bit_count = BITS_W'($urandom_range(1, 32));
    end
    case ($urandom_range(0, 9))
      0: it.bound = 32'd1 << $urandom_range(0, 30);
      1: begin
        case ($urandom_range(0, 4))
          0: it.bound = '0;
          1: it.bound = 32'd1;
          2: it.bound = 32'h7FFF_FFFF;
          3: it.bound = 32'h8000_0000;
          default: it.bound = '1;
        endcase
      end
      2: it.bound = $urandom();
      3, 4, 5: it.bound = $urandom_range(1, 1000);
      default: it.bound = $urandom_range(32'h7FFF_FFFF, 1);
    endcase
    return it;
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_request(request_t it);
    req_bus.valid <= 1'b1;
    req_bus.kind <= it.kind;
    req_bus.seed_value <= it.seed_value;
    req_bus.bit_count <= it.bit_count;
    req_bus.bound <= it.bound;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(it);
  endtask

  // Stop offering and wait until every owed value has come back.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.values_due.size() != 0);
  endtask

  // Register writes back to back; the spare index goes first and must be ignored.
  task automatic configure(logic [CFG_DATA_W-1:0] mult_value,
                           logic [CFG_DATA_W-1:0] inc_value);
    cfg_write_t writes[3];
    writes[0].index = CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE));
    writes[0].data = {16'($urandom()), 32'($urandom())};
    writes[1].index = CFG_MULT;
    writes[1].data = mult_value;
    writes[2].index = CFG_INC;
    writes[2].data = inc_value;
    foreach (writes[w]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= writes[w].index;
      cfg_bus.data <= writes[w].data;
      do @(posedge clk_i); while (!cfg_bus.ready);
      sb.write_register(writes[w].index, writes[w].data);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Random items in bursts; bounded draws that would spin for long get a power of two.
  task automatic run_items(int unsigned count, bit hold_here, bit pause_here);
    request_t it;
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 16);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_here && i == count / 4) holds_asked++;
      if (pause_here && i == count / 2) drain();
      it = random_request();
      if (it.kind == KIND_BOUNDED && sb.bounded_tries(it.bound) > MAX_RANDOM_TRIES) begin
        it.bound = 32'd1 << $urandom_range(0, 30);
      end
      send_request(it);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          req_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    drain();
  endtask

  // Extremes of every field, every kind, and the special cases at reset settings, then a constant generator.
  task automatic run_directed();
    send_request(make_request(KIND_READ, '0, '0, '0));
    send_request(make_request(KIND_ADVANCE, '1, '1, '1));
    send_request(make_request(KIND_BITS, '0, 6'd1, '0));
    send_request(make_request(KIND_BITS, '0, 6'd32, '0));
    send_request(make_request(KIND_BITS, '0, 6'd0, '0));
    send_request(make_request(KIND_BITS, '0, 6'd33, '0));
    send_request(make_request(KIND_BITS, '1, 6'd63, '1));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'd0));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'hFFFF_FFFF));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'h8000_0000));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'd1));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'h4000_0000));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'h7FFF_FFFF));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'd3));
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'h4000_0001));
    send_request(make_request(KIND_LONG, '0, '0, '0));
    send_request(make_request(KIND_DOUBLE, '0, '0, '0));
    send_request(make_request(KIND_SEED, '0, '0, '0));
    send_request(make_request(KIND_SEED, '1, '0, '0));
    send_request(make_request(KIND_SEED, {1'b1, 63'd0}, '0, '0));
    send_request(make_request(KIND_LOAD, {1'b0, {63{1'b1}}}, '0, '0));
    send_request(make_request(KIND_READ, '0, '0, '0));
    send_request(make_request(KIND_ADVANCE, '0, '0, '0));
    send_request(make_request(KIND_LOAD, '1, '1, '1));
    send_request(make_request(KIND_LONG, '0, '0, '0));
    drain();
    // A constant generator whose 31-bit draw always fails the rejection test.
    configure('0, DATA_MAX);
    send_request(make_request(KIND_BOUNDED, '0, '0, 32'h4000_0001));
    drain();
  endtask

  // Result side: checks every accepted value and stalls on its own schedule.
  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode = TAKE_ALL;
    mode_left = 0;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) sb.check_value(rsp_bus.value);
      if (hold_left == 0 && holds_started < holds_asked) begin
        holds_started++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(TAKE_ALL, TAKE_PATTERN));
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (mode)
          TAKE_ALL:     rsp_bus.ready <= 1'b1;
          TAKE_HALF:    rsp_bus.ready <= 1'($urandom_range(0, 1));
          TAKE_QUARTER: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default:      rsp_bus.ready <= (mode_left % 8) < 5;
        endcase
      end
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired after %0d cycles with no item moving", quiet);
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: reset, directed items, then random phases over several settings.
  initial begin
    logic [CFG_DATA_W-1:0] mult_value;
    logic [CFG_DATA_W-1:0] inc_value;
    sb = new();
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.kind <= KIND_READ;
    req_bus.seed_value <= '0;
    req_bus.bit_count <= '0;
    req_bus.bound <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_MULT;
    cfg_bus.data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin
          mult_value = {16'($urandom()), 32'($urandom())} | 48'd1;
          inc_value = {16'($urandom()), 32'($urandom())};
        end
        2: begin
          mult_value = '0;
          inc_value = '0;
        end
        3: begin
          mult_value = DATA_MAX;
          inc_value = DATA_MAX;
        end
        4: begin
          mult_value = DATA_MAX;
          inc_value = '0;
        end
        5: begin
          mult_value = '0;
          inc_value = {16'($urandom()), 32'($urandom())};
        end
        6: begin
          mult_value = {16'($urandom()), 32'($urandom())};
          inc_value = {16'($urandom()), 32'($urandom())};
        end
        default: begin
          mult_value = MULT_RESET;
          inc_value = INC_RESET;
        end
      endcase
      configure(mult_value, inc_value);
      run_items(PHASE_ITEMS, p == HOLD_PHASE, p == PAUSE_PHASE);
    end

    repeat (END_SETTLE) @(posedge clk_i);
    if (sb.values_due.size() != 0) begin
      $display("%0d expected values never arrived", sb.values_due.size());
      sb.mismatches++;
    end

    $display("Requests by kind: seed %0d, load %0d, read %0d, advance %0d, bits %0d, bounded %0d, long %0d, double %0d",
             sb.kind_count[KIND_SEED], sb.kind_count[KIND_LOAD], sb.kind_count[KIND_READ],
             sb.kind_count[KIND_ADVANCE], sb.kind_count[KIND_BITS], sb.kind_count[KIND_BOUNDED],
             sb.kind_count[KIND_LONG], sb.kind_count[KIND_DOUBLE]);
    $display("%0d generator settings, %0d values checked, %0d failures",
             NUM_PHASES + 2, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
